FILE: rtl/bfsa_pkg.sv
package bfsa_pkg;

  localparam int MAX_SEGMENTS_DEF = 16;
  localparam int ADDR_BITS_DEF    = 16;
  localparam int OWNER_BITS_DEF   = 8;

  localparam logic [2:0] ST_GRANT      = 3'd0;
  localparam logic [2:0] ST_GRANT_COMP = 3'd1;
  localparam logic [2:0] ST_NO_SPACE   = 3'd2;
  localparam logic [2:0] ST_FREED      = 3'd3;
  localparam logic [2:0] ST_TABLE_FULL = 3'd4;

  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

  typedef struct packed {
    logic        req_type;
    logic [7:0]  owner_id;
    logic [15:0] req_size;
  } bfsa_in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] start_addr;
  } bfsa_out_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_FREE_SCAN,
    S_FIT_SCAN,
    S_GRANT,
    S_CMP_HOLE,
    S_CMP_CAND,
    S_MRG_SCAN,
    S_MRG_SHIFT,
    S_INS_SHIFT,
    S_DONE
  } bfsa_state_t;

  // commands from controller to datapath
  typedef struct packed {
    logic init;         // re-initialize table
    logic latch_req;    // capture request
    logic clr_i;        // i <= 0
    logic inc_i;        // i <= i+1
    logic set_j_last;   // j <= count-1
    logic dec_j;        // j <= j-1
    logic free_step;    // release entry i if owned
    logic fit_step;     // evaluate entry i for best fit
    logic do_grant;     // mark best as allocated; with start_split, split best instead
    logic start_split;  // set up insert at best+1 (grant) or i+1 (move)
    logic ins_step;     // one shift of insert; writes on final step
    logic mrg_merge;    // merge i and i+1, start remove
    logic rm_step;      // one shift of remove
    logic do_move_exact;
    logic set_compacted;
    logic set_result;
    logic [2:0] result_status;
    logic result_addr;  // use best start
  } bfsa_cmd_t;

  typedef struct packed {
    logic       i_end;      // i >= count
    logic       i_pair_end; // i+1 >= count
    logic       i_used;
    logic       j_gt_i;
    logic       j_cand;     // j used and fits into hole i
    logic       j_exact;
    logic       full;
    logic       found;
    logic       best_exact;
    logic       mrg_pair;   // i,i+1 both free and adjacent
    logic       shift_done; // insert shifting finished
    logic       rm_last;    // remove shifting at its last entry
    logic       compacted;
    logic       is_free;
    logic       size_zero;
  } bfsa_sts_t;

endpackage

FILE: rtl/bfsa_datapath.sv
module bfsa_datapath #(
  parameter int MAX_SEGMENTS = bfsa_pkg::MAX_SEGMENTS_DEF,
  parameter int ADDR_BITS    = bfsa_pkg::ADDR_BITS_DEF,
  parameter int OWNER_BITS   = bfsa_pkg::OWNER_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [15:0]           mem_size,
  input  bfsa_pkg::bfsa_in_t    req,
  input  bfsa_pkg::bfsa_cmd_t   cmd,
  output bfsa_pkg::bfsa_sts_t   sts,
  output bfsa_pkg::bfsa_out_t   result
);
  import bfsa_pkg::*;

  localparam int IW = $clog2(MAX_SEGMENTS);
  localparam int CW = $clog2(MAX_SEGMENTS + 1);
  localparam logic [ADDR_BITS-1:0] AMAX = {ADDR_BITS{1'b1}};

  typedef struct packed {
    logic [ADDR_BITS-1:0]  lo;
    logic [ADDR_BITS-1:0]  hi;
    logic                  used;
    logic [OWNER_BITS-1:0] owner;
  } seg_t;

  seg_t                  tab_r [MAX_SEGMENTS];
  logic [CW-1:0]         cnt_r;
  logic [CW-1:0]         i_r, j_r, p_r, best_r, tgt_r;
  logic [ADDR_BITS-1:0]  best_left_r;
  logic                  found_r, compacted_r;
  logic                  req_type_r;
  logic [OWNER_BITS-1:0] owner_r;
  logic [ADDR_BITS-1:0]  size_r;
  seg_t                  ins_r;
  bfsa_out_t             res_r;

  seg_t si, sj, si1, sb;
  logic [ADDR_BITS-1:0] len_i, len_j, len_b;
  logic [ADDR_BITS-1:0] mem_sat;

  always_comb begin
    si   = tab_r[i_r[IW-1:0]];
    si1  = tab_r[IW'(i_r + 1'b1)];
    sj   = tab_r[j_r[IW-1:0]];
    sb   = tab_r[best_r[IW-1:0]];
    len_i = si.hi - si.lo;
    len_j = sj.hi - sj.lo;
    len_b = sb.hi - sb.lo;
    if (ADDR_BITS >= 16) mem_sat = ADDR_BITS'(mem_size);
    else mem_sat = (mem_size > 16'(AMAX)) ? AMAX : mem_size[ADDR_BITS-1:0];
  end

  always_comb begin
    sts.i_end      = (i_r >= cnt_r);
    sts.i_pair_end = ({1'b0, i_r} + 1'b1 >= {1'b0, cnt_r});
    sts.i_used     = si.used;
    sts.j_gt_i     = (j_r > i_r);
    sts.j_cand     = sj.used && (len_j <= len_i);
    sts.j_exact    = (len_j == len_i);
    sts.full       = (cnt_r >= CW'(MAX_SEGMENTS));
    sts.found      = found_r;
    sts.best_exact = (len_b == size_r);
    sts.mrg_pair   = !si.used && !si1.used && (si.hi == si1.lo);
    sts.shift_done = (p_r <= tgt_r);
    sts.rm_last    = (p_r >= tgt_r);
    sts.compacted  = compacted_r;
    sts.is_free    = (req_type_r == REQ_FREE);
    sts.size_zero  = (size_r == '0);
  end

  assign result = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.init) begin
      tab_r[0] <= '{lo: '0, hi: (rst_n ? mem_sat : AMAX), used: 1'b0, owner: '0};
      for (int k = 1; k < MAX_SEGMENTS; k++) tab_r[k] <= '0;
      cnt_r       <= CW'(1);
      found_r     <= 1'b0;
      compacted_r <= 1'b0;
      i_r <= '0; j_r <= '0; p_r <= '0; best_r <= '0; tgt_r <= '0;
    end else begin
      if (cmd.latch_req) begin
        req_type_r  <= req.req_type;
        owner_r     <= req.owner_id[OWNER_BITS-1:0];
        size_r      <= ADDR_BITS'(req.req_size);
        compacted_r <= 1'b0;
      end
      if (cmd.clr_i) begin
        i_r     <= '0;
        found_r <= 1'b0;
      end
      if (cmd.inc_i) i_r <= i_r + 1'b1;
      if (cmd.set_j_last) j_r <= cnt_r - 1'b1;
      if (cmd.dec_j) j_r <= j_r - 1'b1;
      if (cmd.set_compacted) compacted_r <= 1'b1;
      if (cmd.free_step && si.used && si.owner == owner_r) begin
        tab_r[i_r[IW-1:0]].used  <= 1'b0;
        tab_r[i_r[IW-1:0]].owner <= '0;
      end
      if (cmd.fit_step && !si.used && len_i >= size_r) begin
        if (!found_r || (len_i - size_r) < best_left_r) begin
          found_r     <= 1'b1;
          best_left_r <= len_i - size_r;
          best_r      <= i_r;
        end
      end
      if (cmd.start_split) begin
        // grant split of best, or compaction move of j into hole i
        if (cmd.do_grant) begin
          ins_r.lo <= sb.lo + size_r;
          ins_r.hi <= sb.hi;
          tab_r[best_r[IW-1:0]].hi <= sb.lo + size_r;
          tgt_r <= best_r + 1'b1;
        end else begin
          ins_r.lo <= si.lo + len_j;
          ins_r.hi <= si.hi;
          tab_r[i_r[IW-1:0]].hi    <= si.lo + len_j;
          tab_r[i_r[IW-1:0]].used  <= 1'b1;
          tab_r[i_r[IW-1:0]].owner <= sj.owner;
          tab_r[j_r[IW-1:0]].used  <= 1'b0;
          tab_r[j_r[IW-1:0]].owner <= '0;
          tgt_r <= i_r + 1'b1;
        end
        ins_r.used  <= 1'b0;
        ins_r.owner <= '0;
        p_r <= cnt_r;
      end else if (cmd.do_grant) begin
        tab_r[best_r[IW-1:0]].used  <= 1'b1;
        tab_r[best_r[IW-1:0]].owner <= owner_r;
      end
      if (cmd.ins_step) begin
        if (p_r > tgt_r) begin
          tab_r[p_r[IW-1:0]] <= tab_r[IW'(p_r - 1'b1)];
          p_r <= p_r - 1'b1;
        end else begin
          tab_r[tgt_r[IW-1:0]] <= ins_r;
          cnt_r <= cnt_r + 1'b1;
        end
      end
      if (cmd.do_move_exact) begin
        tab_r[i_r[IW-1:0]].used  <= 1'b1;
        tab_r[i_r[IW-1:0]].owner <= sj.owner;
        tab_r[j_r[IW-1:0]].used  <= 1'b0;
        tab_r[j_r[IW-1:0]].owner <= '0;
      end
      if (cmd.mrg_merge) begin
        tab_r[i_r[IW-1:0]].hi <= si1.hi;
        p_r   <= i_r + 1'b1;
        tgt_r <= cnt_r - 1'b1;
      end
      if (cmd.rm_step) begin
        // p walks up; tgt is last index
        if (p_r < tgt_r) begin
          tab_r[p_r[IW-1:0]] <= tab_r[IW'(p_r + 1'b1)];
          p_r <= p_r + 1'b1;
        end else begin
          tab_r[tgt_r[IW-1:0]] <= '0;
          cnt_r <= cnt_r - 1'b1;
          p_r <= '0;
          tgt_r <= '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.set_result) begin
      res_r.status     <= cmd.result_status;
      res_r.start_addr <= cmd.result_addr ? 16'(sb.lo) : 16'd0;
    end
  end

endmodule

FILE: rtl/bfsa_ctrl.sv
module bfsa_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  output logic                out_valid,
  input  logic                out_stall,
  input  bfsa_pkg::bfsa_sts_t sts,
  output bfsa_pkg::bfsa_cmd_t cmd
);
  import bfsa_pkg::*;

  bfsa_state_t state_r, state_nxt;
  logic        ins_grant_r, ins_grant_nxt; // insert belongs to a grant

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = (state_r == S_DONE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ins_grant_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ins_grant_r <= ins_grant_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    ins_grant_nxt = ins_grant_r;
    unique case (state_r)
      S_IDLE:      if (in_valid) state_nxt = S_FREE_SCAN;
      S_FREE_SCAN: begin
        if (!sts.is_free) state_nxt = sts.size_zero ? S_DONE : S_FIT_SCAN;
        else if (sts.i_end) state_nxt = S_MRG_SCAN;
      end
      S_FIT_SCAN:  if (sts.i_end) state_nxt = S_GRANT;
      S_GRANT: begin
        if (!sts.found) state_nxt = sts.compacted ? S_DONE : S_CMP_HOLE;
        else if (sts.best_exact || sts.full) state_nxt = S_DONE;
        else begin
          state_nxt     = S_INS_SHIFT;
          ins_grant_nxt = 1'b1;
        end
      end
      S_CMP_HOLE: begin
        if (sts.i_pair_end) state_nxt = S_MRG_SCAN;
        else if (!sts.i_used) state_nxt = S_CMP_CAND;
      end
      S_CMP_CAND: begin
        if (!sts.j_gt_i) state_nxt = S_CMP_HOLE;
        else if (sts.j_cand && sts.j_exact) state_nxt = S_CMP_HOLE;
        else if (sts.j_cand && !sts.full) begin
          state_nxt     = S_INS_SHIFT;
          ins_grant_nxt = 1'b0;
        end
      end
      S_INS_SHIFT: if (sts.shift_done) state_nxt = ins_grant_r ? S_DONE : S_CMP_HOLE;
      S_MRG_SCAN: begin
        if (sts.i_pair_end) state_nxt = sts.is_free ? S_DONE : S_FIT_SCAN;
        else if (sts.mrg_pair) state_nxt = S_MRG_SHIFT;
      end
      S_MRG_SHIFT: if (sts.rm_last) state_nxt = S_MRG_SCAN;
      S_DONE:      if (!out_stall) state_nxt = S_IDLE;
      default:     state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    unique case (state_r)
      S_IDLE: if (in_valid) begin
        cmd.latch_req = 1'b1;
        cmd.clr_i     = 1'b1;
      end
      S_FREE_SCAN: begin
        if (!sts.is_free) begin
          if (sts.size_zero) begin
            cmd.set_result    = 1'b1;
            cmd.result_status = ST_NO_SPACE;
          end
        end else if (sts.i_end) cmd.clr_i = 1'b1;
        else begin
          cmd.free_step = 1'b1;
          cmd.inc_i     = 1'b1;
        end
      end
      S_FIT_SCAN: if (!sts.i_end) begin
        cmd.fit_step = 1'b1;
        cmd.inc_i    = 1'b1;
      end
      S_GRANT: begin
        if (!sts.found) begin
          if (sts.compacted) begin
            cmd.set_result    = 1'b1;
            cmd.result_status = ST_NO_SPACE;
          end else begin
            cmd.clr_i         = 1'b1;
            cmd.set_compacted = 1'b1;
          end
        end else if (sts.best_exact) begin
          cmd.do_grant      = 1'b1;
          cmd.set_result    = 1'b1;
          cmd.result_addr   = 1'b1;
          cmd.result_status = sts.compacted ? ST_GRANT_COMP : ST_GRANT;
        end else if (sts.full) begin
          cmd.set_result    = 1'b1;
          cmd.result_status = ST_TABLE_FULL;
        end else begin
          cmd.do_grant    = 1'b1;
          cmd.start_split = 1'b1;
        end
      end
      S_CMP_HOLE: begin
        if (sts.i_pair_end) cmd.clr_i = 1'b1;
        else if (sts.i_used) cmd.inc_i = 1'b1;
        else cmd.set_j_last = 1'b1;
      end
      S_CMP_CAND: begin
        if (!sts.j_gt_i) cmd.inc_i = 1'b1;
        else if (sts.j_cand && sts.j_exact) begin
          cmd.do_move_exact = 1'b1;
          cmd.clr_i         = 1'b1;
        end else if (sts.j_cand && !sts.full) cmd.start_split = 1'b1;
        else cmd.dec_j = 1'b1;
      end
      S_INS_SHIFT: begin
        cmd.ins_step = 1'b1;
        if (sts.shift_done) begin
          if (ins_grant_r) begin
            // mark and report in the same cycle as the insert lands
            cmd.do_grant      = 1'b1;
            cmd.set_result    = 1'b1;
            cmd.result_addr   = 1'b1;
            cmd.result_status = sts.compacted ? ST_GRANT_COMP : ST_GRANT;
          end else cmd.clr_i = 1'b1;
        end
      end
      S_MRG_SCAN: begin
        if (sts.i_pair_end) begin
          cmd.clr_i = 1'b1;
          if (sts.is_free) begin
            cmd.set_result    = 1'b1;
            cmd.result_status = ST_FREED;
          end
        end else if (sts.mrg_pair) cmd.mrg_merge = 1'b1;
        else cmd.inc_i = 1'b1;
      end
      S_MRG_SHIFT: cmd.rm_step = 1'b1;
      S_DONE: ;
      default: ;
    endcase
  end

endmodule

FILE: rtl/best_fit_segment_allocator.sv
// Channel   Dir  Handshake           Payload
// in_       in   in_valid/in_stall   bfsa_in_t  {req_type, owner_id, req_size}
// out_      out  out_valid/out_stall bfsa_out_t {status, start_addr}
// cfg_      in   APB write/read      mem_size register at address 0
// One request at a time; in_stall is high from acceptance until the result is taken.
// Allocate: a decode step, a fit scan over all entries and a grant step, plus shifts of
// the entries above best on a split. Free: a release scan over all entries, then a merge
// scan; each merge removes one entry, shifting the entries above it one per cycle.
// A failed fit adds compaction, restarted after every move, then a merge pass and a
// second fit. Reset leaves one free segment [0, 65535).
module best_fit_segment_allocator #(
  parameter int MAX_SEGMENTS = bfsa_pkg::MAX_SEGMENTS_DEF,
  parameter int ADDR_BITS    = bfsa_pkg::ADDR_BITS_DEF,
  parameter int OWNER_BITS   = bfsa_pkg::OWNER_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  bfsa_pkg::bfsa_in_t in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output bfsa_pkg::bfsa_out_t out_data,
  input  logic               cfg_psel,
  input  logic               cfg_penable,
  input  logic               cfg_pwrite,
  input  logic [1:0]         cfg_paddr,
  input  logic [31:0]        cfg_pwdata,
  output logic [31:0]        cfg_prdata,
  output logic               cfg_pready
);
  import bfsa_pkg::*;

  localparam logic [1:0] REG_MEM_SIZE = 2'd0;

  logic [15:0] mem_size_r;
  logic        cfg_wr;
  bfsa_cmd_t   cmd, cmd_dp;
  bfsa_sts_t   sts;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && (cfg_paddr == REG_MEM_SIZE);
  assign cfg_prdata = (cfg_paddr == REG_MEM_SIZE) ? {16'd0, mem_size_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) mem_size_r <= 16'hFFFF;
    else if (cfg_wr) mem_size_r <= cfg_pwdata[15:0];
  end

  // table re-init in the cycle after the register write
  logic init_r;
  always_ff @(posedge clk) begin
    if (!rst_n) init_r <= 1'b0;
    else init_r <= cfg_wr;
  end

  always_comb begin
    cmd_dp      = cmd;
    cmd_dp.init = init_r;
  end

  bfsa_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  bfsa_datapath #(
    .MAX_SEGMENTS(MAX_SEGMENTS),
    .ADDR_BITS   (ADDR_BITS),
    .OWNER_BITS  (OWNER_BITS)
  ) u_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .mem_size(mem_size_r),
    .req     (in_data),
    .cmd     (cmd_dp),
    .sts     (sts),
    .result  (out_data)
  );

endmodule
